@@ rtl/qsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsp_pkg
// Shared codes and helpers for the qubit staging prefetch policy.
// ----------------------------------------------------------------------------
package qsp_pkg;

	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_SWAP  = 2'd1;
	localparam logic [1:0] OP_LOOK  = 2'd2;
	localparam logic [1:0] OP_EOL   = 2'd3;

	localparam logic [1:0] LOC_COLD    = 2'd0;
	localparam logic [1:0] LOC_COMPUTE = 2'd1;
	localparam logic [1:0] LOC_EVICT   = 2'd2;
	localparam logic [1:0] LOC_PREF    = 2'd3;

	localparam logic [2:0] KIND_ACK    = 3'd0;
	localparam logic [2:0] KIND_SHIT   = 3'd1;
	localparam logic [2:0] KIND_PHIT   = 3'd2;
	localparam logic [2:0] KIND_COLD   = 3'd3;
	localparam logic [2:0] KIND_PF     = 3'd4;
	localparam logic [2:0] KIND_LDONE  = 3'd5;

	localparam logic [1:0] REG_ACTIVE  = 2'd0;
	localparam logic [1:0] REG_STAGING = 2'd1;
	localparam logic [1:0] REG_INUSE   = 2'd2;
	localparam logic [1:0] REG_SEED    = 2'd3;

	localparam logic [15:0] LFSR_MASK  = 16'hB400;
	localparam logic [8:0]  UNMET_MAX  = 9'h1FF;

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [15:0] lfsr_step(input logic [15:0] v);
		lfsr_step = {1'b0, v[15:1]} ^ (v[0] ? LFSR_MASK : 16'h0000);
	endfunction

endpackage

@@ rtl/qsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsp_req_if / qsp_rsp_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface qsp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] load_qubit;
	logic [7:0] store_qubit;

	modport source (output valid, opcode, load_qubit, store_qubit, input ready);
	modport sink   (input valid, opcode, load_qubit, store_qubit, output ready);
endinterface

interface qsp_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  fetched_qubit;
	logic [7:0]  victim_qubit;
	logic [8:0]  unmet_needs;
	logic [31:0] prefetch_total;
	logic [31:0] cold_count;
	logic        last;

	modport source (output valid, kind, fetched_qubit, victim_qubit, unmet_needs,
		prefetch_total, cold_count, last, input ready);
	modport sink   (input valid, kind, fetched_qubit, victim_qubit, unmet_needs,
		prefetch_total, cold_count, last, output ready);
endinterface

@@ rtl/qsp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qsp_ram #(
	parameter int W = 3,
	parameter int D = 256,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/qsp_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsp_mod
// Restoring remainder unit: 16-bit dividend, one bit per cycle.
// ----------------------------------------------------------------------------
module qsp_mod #(
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [15:0]   dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [VW-1:0] rem
);
	logic [VW-1:0] rem_q;
	logic [15:0]   dvd_q;
	logic [VW-1:0] dvs_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic [VW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q, dvd_q[15]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(rem_sh - {1'b0, dvs_q}) : rem_sh[VW-1:0];
			dvd_q <= {dvd_q[14:0], 1'b0};
		end
	end

	assign rem = rem_q;
endmodule

@@ rtl/qubit_staging_prefetch_policy.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qubit_staging_prefetch_policy
// Lookahead prefetch with LFSR-chosen eviction over a qubit location table.
// ----------------------------------------------------------------------------
// Swap runs S_SW_LD, S_SW_ST, S_ACK; lookahead S_LA, S_ACK; a qubit out of range goes straight
// to S_ACK; one item at a time. Init: a write sweep of the location RAM.
// End of layer: a repartition sweep, then per queued need a skip if unmet or no longer cold,
//   else a division on the 16-step remainder unit plus a victim scan over the location
//   table for the chosen evictable entry; layer done is registered after the last need.
// After reset a clearing pass runs before the first item.
module qubit_staging_prefetch_policy #(
	parameter int QUBIT_COUNT = 256,
	parameter int MAX_COLD_NEEDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	qsp_req_if.sink     req,
	qsp_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);
	import qsp_pkg::*;

	localparam int QW   = $clog2(QUBIT_COUNT);
	localparam int CW   = $clog2(QUBIT_COUNT + 1);
	localparam int NW   = $clog2(MAX_COLD_NEEDS + 1);
	localparam int QIW  = (MAX_COLD_NEEDS > 1) ? $clog2(MAX_COLD_NEEDS) : 1;
	localparam int CMPW = (CW > 11) ? CW : 11;

	typedef enum logic [15:0] {
		S_CLR   = 16'h0001,
		S_IDLE  = 16'h0002,
		S_INIT  = 16'h0004,
		S_SW_LD = 16'h0008,
		S_SW_ST = 16'h0010,
		S_LA    = 16'h0020,
		S_PART  = 16'h0040,
		S_QRD   = 16'h0080,
		S_NRD   = 16'h0100,
		S_NCHK  = 16'h0200,
		S_DIV   = 16'h0400,
		S_SCAN  = 16'h0800,
		S_WVIC  = 16'h1000,
		S_WNEED = 16'h2000,
		S_DONE  = 16'h4000,
		S_ACK   = 16'h8000
	} state_t;

	state_t        state_q;
	logic [8:0]    act_q, stg_q, inuse_q;
	logic [15:0]   seed_q;
	logic [CW-1:0] q_ctr_q;
	logic          sv_s1;
	logic [QW-1:0] a_s1;
	logic [7:0]    ld_q, st_q;
	logic [2:0]    kind_q;
	logic [2:0]    fwd_q;
	logic [15:0]   lfsr_q;
	logic [CW-1:0] evict_q;
	logic [NW-1:0] qcnt_q, qi_q;
	logic [8:0]    ovf_q, unmet_q;
	logic [7:0]    need_q;
	logic [CW-1:0] r_q;
	logic [QW-1:0] victim_q;
	logic [31:0]   pref_q, cold_q;
	logic          out_v_q;
	logic          out_free;

	logic          lm_we;
	logic [QW-1:0] lm_waddr, lm_raddr;
	logic [2:0]    lm_wdata, lm_rdata;
	logic          qm_we;
	logic [7:0]    qm_rdata;
	logic [2:0]    ent_st;
	logic [1:0]    init_loc, part_loc;
	logic          hit;
	logic          ld_oob, st_oob;
	logic          div_start, div_done;
	logic [15:0]   lfsr_nx;
	logic [CW-1:0] div_rem;
	logic [CMPW-1:0] qx;

	qsp_ram #(.W(3), .D(QUBIT_COUNT)) u_loc (
		.clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
		.raddr(lm_raddr), .rdata(lm_rdata)
	);

	qsp_ram #(.W(8), .D(MAX_COLD_NEEDS)) u_queue (
		.clk(clk), .we(qm_we), .waddr(qcnt_q[QIW-1:0]), .wdata(ld_q),
		.raddr(qi_q[QIW-1:0]), .rdata(qm_rdata)
	);

	qsp_mod #(.VW(CW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(lfsr_nx),
		.divisor(evict_q), .done(div_done), .rem(div_rem)
	);

	assign out_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign ld_oob = 32'(req.load_qubit) >= QUBIT_COUNT;
	assign st_oob = 32'(req.store_qubit) >= QUBIT_COUNT;
	assign hit = (kind_q != KIND_COLD);
	assign ent_st = (st_q == ld_q) ? fwd_q : lm_rdata;
	assign lfsr_nx = lfsr_step(lfsr_q);
	assign qx = CMPW'(q_ctr_q);
	assign div_start = (state_q == S_NCHK) && (lm_rdata[1:0] == LOC_COLD)
		&& (evict_q != '0);

	always_comb begin
		if (qx < CMPW'(act_q)) begin
			init_loc = LOC_COMPUTE;
		end else if (qx < CMPW'(act_q) + CMPW'(stg_q) && qx < CMPW'(inuse_q)) begin
			init_loc = LOC_EVICT;
		end else begin
			init_loc = LOC_COLD;
		end
		if (lm_rdata[1:0] == LOC_EVICT || lm_rdata[1:0] == LOC_PREF) begin
			part_loc = lm_rdata[2] ? LOC_PREF : LOC_EVICT;
		end else begin
			part_loc = lm_rdata[1:0];
		end
	end

	always_comb begin
		lm_we    = 1'b0;
		lm_waddr = q_ctr_q[QW-1:0];
		lm_wdata = {1'b0, LOC_COLD};
		lm_raddr = q_ctr_q[QW-1:0];
		qm_we    = 1'b0;
		case (state_q)
			S_CLR: begin
				lm_we = 1'b1;
			end
			S_IDLE: begin
				lm_raddr = QW'(req.load_qubit);
			end
			S_INIT: begin
				lm_we    = 1'b1;
				lm_wdata = {1'b0, init_loc};
			end
			S_SW_LD: begin
				lm_we    = 1'b1;
				lm_waddr = QW'(ld_q);
				lm_wdata = {lm_rdata[2], LOC_COMPUTE};
				lm_raddr = QW'(st_q);
			end
			S_SW_ST: begin
				lm_waddr = QW'(st_q);
				if (hit) begin
					lm_we    = ent_st[1:0] != LOC_PREF;
					lm_wdata = {ent_st[2], LOC_EVICT};
				end else begin
					lm_we    = ent_st[1:0] == LOC_COMPUTE;
					lm_wdata = {ent_st[2], LOC_COLD};
				end
			end
			S_LA: begin
				lm_waddr = QW'(ld_q);
				lm_we    = !lm_rdata[2];
				lm_wdata = {1'b1, lm_rdata[1:0]};
				qm_we    = !lm_rdata[2] && lm_rdata[1:0] == LOC_COLD
					&& 32'(qcnt_q) < MAX_COLD_NEEDS;
			end
			S_PART: begin
				lm_we    = sv_s1;
				lm_waddr = a_s1;
				lm_wdata = {1'b0, part_loc};
			end
			S_NRD: begin
				lm_raddr = QW'(qm_rdata);
			end
			S_WVIC: begin
				lm_we    = 1'b1;
				lm_waddr = victim_q;
			end
			S_WNEED: begin
				lm_we    = out_free;
				lm_waddr = QW'(need_q);
				lm_wdata = {1'b0, LOC_PREF};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= '0;
			stg_q   <= '0;
			inuse_q <= 9'd256;
			seed_q  <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ACTIVE:  act_q   <= cfg_wdata[8:0];
				REG_STAGING: stg_q   <= cfg_wdata[8:0];
				REG_INUSE:   inuse_q <= cfg_wdata[8:0];
				REG_SEED:    seed_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			q_ctr_q  <= '0;
			sv_s1    <= 1'b0;
			a_s1     <= '0;
			ld_q     <= '0;
			st_q     <= '0;
			fwd_q    <= '0;
			need_q   <= '0;
			r_q      <= '0;
			victim_q <= '0;
			lfsr_q   <= 16'd1;
			evict_q  <= '0;
			qcnt_q   <= '0;
			qi_q     <= '0;
			ovf_q    <= '0;
			unmet_q  <= '0;
			pref_q   <= '0;
			cold_q   <= '0;
			kind_q   <= KIND_ACK;
		end else begin
			case (state_q)
				S_CLR: begin
					q_ctr_q <= q_ctr_q + 1'b1;
					if (q_ctr_q == CW'(QUBIT_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					kind_q  <= KIND_ACK;
					q_ctr_q <= '0;
					sv_s1   <= 1'b0;
					if (req.valid) begin
						ld_q <= req.load_qubit;
						st_q <= req.store_qubit;
						case (req.opcode)
							OP_INIT: begin
								evict_q <= '0;
								qcnt_q  <= '0;
								ovf_q   <= '0;
								pref_q  <= '0;
								cold_q  <= '0;
								lfsr_q  <= (seed_q != '0) ? seed_q : 16'd1;
								state_q <= S_INIT;
							end
							OP_SWAP: state_q <= (ld_oob || st_oob) ? S_ACK : S_SW_LD;
							OP_LOOK: state_q <= ld_oob ? S_ACK : S_LA;
							OP_EOL: begin
								unmet_q <= ovf_q;
								state_q <= S_PART;
							end
							default: state_q <= S_ACK;
						endcase
					end
				end
				S_INIT: begin
					q_ctr_q <= q_ctr_q + 1'b1;
					if (init_loc == LOC_EVICT) begin
						evict_q <= evict_q + 1'b1;
					end
					if (q_ctr_q == CW'(QUBIT_COUNT - 1)) begin
						state_q <= S_ACK;
					end
				end
				S_SW_LD: begin
					fwd_q <= {lm_rdata[2], LOC_COMPUTE};
					if (lm_rdata[1:0] == LOC_EVICT) begin
						evict_q <= evict_q - 1'b1;
						kind_q  <= KIND_SHIT;
					end else if (lm_rdata[1:0] == LOC_PREF) begin
						kind_q  <= KIND_PHIT;
					end else begin
						kind_q  <= KIND_COLD;
						cold_q  <= sat_inc32(cold_q);
					end
					state_q <= S_SW_ST;
				end
				S_SW_ST: begin
					if (hit && ent_st[1:0] != LOC_PREF && ent_st[1:0] != LOC_EVICT) begin
						evict_q <= evict_q + 1'b1;
					end
					state_q <= S_ACK;
				end
				S_LA: begin
					if (!lm_rdata[2] && lm_rdata[1:0] == LOC_COLD) begin
						if (32'(qcnt_q) < MAX_COLD_NEEDS) begin
							qcnt_q <= qcnt_q + 1'b1;
						end else if (ovf_q != UNMET_MAX) begin
							ovf_q <= ovf_q + 9'd1;
						end
					end
					state_q <= S_ACK;
				end
				S_PART: begin
					sv_s1 <= 32'(q_ctr_q) < QUBIT_COUNT;
					a_s1  <= q_ctr_q[QW-1:0];
					if (32'(q_ctr_q) < QUBIT_COUNT) begin
						q_ctr_q <= q_ctr_q + 1'b1;
					end
					if (sv_s1) begin
						if (lm_rdata[1:0] == LOC_EVICT && lm_rdata[2]) begin
							evict_q <= evict_q - 1'b1;
						end else if (lm_rdata[1:0] == LOC_PREF && !lm_rdata[2]) begin
							evict_q <= evict_q + 1'b1;
						end
					end
					if (sv_s1 && a_s1 == QW'(QUBIT_COUNT - 1)) begin
						qi_q    <= '0;
						state_q <= S_QRD;
					end
				end
				S_QRD: begin
					state_q <= (qi_q < qcnt_q) ? S_NRD : S_DONE;
				end
				S_NRD: begin
					need_q  <= qm_rdata;
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					qi_q <= qi_q + 1'b1;
					if (lm_rdata[1:0] != LOC_COLD) begin
						state_q <= S_QRD;
					end else if (evict_q == '0) begin
						if (unmet_q != UNMET_MAX) begin
							unmet_q <= unmet_q + 9'd1;
						end
						state_q <= S_QRD;
					end else begin
						lfsr_q  <= lfsr_nx;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					q_ctr_q <= '0;
					sv_s1   <= 1'b0;
					if (div_done) begin
						r_q     <= div_rem;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					sv_s1 <= 32'(q_ctr_q) < QUBIT_COUNT;
					a_s1  <= q_ctr_q[QW-1:0];
					if (32'(q_ctr_q) < QUBIT_COUNT) begin
						q_ctr_q <= q_ctr_q + 1'b1;
					end
					if (sv_s1 && lm_rdata[1:0] == LOC_EVICT) begin
						if (r_q == '0) begin
							victim_q <= a_s1;
							state_q  <= S_WVIC;
						end else begin
							r_q <= r_q - 1'b1;
						end
					end
				end
				S_WVIC: begin
					evict_q <= evict_q - 1'b1;
					state_q <= S_WNEED;
				end
				S_WNEED: begin
					if (out_free) begin
						pref_q  <= sat_inc32(pref_q);
						state_q <= S_QRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						qcnt_q  <= '0;
						ovf_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_ACK: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free && (state_q == S_ACK || state_q == S_WNEED
			|| state_q == S_DONE)) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			rsp.fetched_qubit  <= '0;
			rsp.victim_qubit   <= '0;
			rsp.unmet_needs    <= '0;
			rsp.prefetch_total <= pref_q;
			rsp.cold_count     <= cold_q;
			rsp.last           <= 1'b1;
			rsp.kind           <= kind_q;
			if (state_q == S_WNEED) begin
				rsp.kind           <= KIND_PF;
				rsp.fetched_qubit  <= need_q;
				rsp.victim_qubit   <= 8'(victim_q);
				rsp.prefetch_total <= sat_inc32(pref_q);
				rsp.last           <= 1'b0;
			end else if (state_q == S_DONE) begin
				rsp.kind        <= KIND_LDONE;
				rsp.unmet_needs <= unmet_q;
			end
		end
	end

	assign rsp.valid = out_v_q;

	a_evict_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(evict_q) <= QUBIT_COUNT)
		else $error("evictable count out of range");

	a_queue_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(qcnt_q) <= MAX_COLD_NEEDS)
		else $error("cold need count out of range");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_rem < evict_q)
		else $error("victim index beyond evictable count");

	a_victim_evict: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WVIC |-> $past(lm_rdata[1:0]) == LOC_EVICT)
		else $error("victim was not evictable");

endmodule
